[hdl/c2d_pkg.sv]
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants for the 2-D same-padding convolution block.
// ----------------------------------------------------------------------------
package c2d_pkg;

   // request field widths
   localparam int OP_W    = 2;
   localparam int POS_W   = 6;
   localparam int VALUE_W = 16;

   // response sum width
   localparam int SUM_W = 37;

   // signed window coordinate: request position plus/minus kernel offset
   localparam int WIN_W = 9;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int KLEN_W     = 3;
   localparam int DIM_W      = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_KERNEL   = 2'd3;

   // operation codes
   localparam logic [OP_W-1:0] OP_KERNEL_WR = 2'd0;
   localparam logic [OP_W-1:0] OP_PIXEL_WR  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

[hdl/c2d_ram.sv]
// ----------------------------------------------------------------------------
// c2d_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module c2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/conv2d_same_padding.sv]
// ----------------------------------------------------------------------------
// conv2d_same_padding
// 2-D sliding-window filter, zero padding, output the same size as the image.
//
// Usage:
//   req_ channel carries one request: write a kernel coefficient, write an
//   image pixel, or compute one output position. Writes are accepted while idle
//   and give no response. A compute request gives one rsp_ item.
//   csr_ channel writes kernel_length, image_rows, image_cols, flip_kernel;
//   it is always ready and must only be used while no compute is pending.
//   Compute: the sequencer walks the L x L window, one kernel/pixel read
//   pair and one multiply-accumulate per cycle, limited by the single read
//   port of each RAM. req_ready returns in the same cycle as the new
//   response appears on rsp_, so computes do not overlap. A position outside
//   the image, or L = 0, skips the window walk and responds with sum 0.
//   The response sits in an output register; while the receiver stalls the
//   block keeps taking writes and one further compute, which then waits for
//   the output register to free up.
//   Reset (synchronous, active high) restores the registers to L = 3,
//   64 x 64, correlation; RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module conv2d_same_padding #(
   parameter int MAX_KERNEL = 7,
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [c2d_pkg::OP_W-1:0]            req_operation,
   input  logic [c2d_pkg::POS_W-1:0]           req_row,
   input  logic [c2d_pkg::POS_W-1:0]           req_col,
   input  logic signed [c2d_pkg::VALUE_W-1:0]  req_value,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [c2d_pkg::SUM_W-1:0]    rsp_sum,
   output logic [c2d_pkg::POS_W-1:0]           rsp_out_row,
   output logic [c2d_pkg::POS_W-1:0]           rsp_out_col,
   output logic                                rsp_position_error,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [c2d_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [c2d_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
   localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
   localparam int IDEPTH = MAX_ROWS * MAX_COLS;
   localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
   localparam int KW     = $clog2(MAX_KERNEL + 1);
   localparam int PW     = 2 * DATA_WIDTH;
   localparam int WW     = c2d_pkg::WIN_W;

   // configuration registers
   logic [c2d_pkg::KLEN_W-1:0] kernel_len_ff;
   logic [c2d_pkg::DIM_W-1:0]  image_rows_ff;
   logic [c2d_pkg::DIM_W-1:0]  image_cols_ff;
   logic                       flip_ff;

   // control
   c2d_pkg::state_type state_ff, state_in;
   logic          start, issue, load_rsp;
   logic          p1_ff, p2_ff, in1_ff, in2_ff;
   logic          rsp_valid_ff;
   logic [KW-1:0] i_ff, j_ff;

   // payload
   logic [c2d_pkg::POS_W-1:0]        row_ff, col_ff;
   logic                             err_ff;
   logic signed [PW-1:0]             prod_ff;
   logic signed [c2d_pkg::SUM_W-1:0] acc_ff;
   logic signed [c2d_pkg::SUM_W-1:0] rsp_sum_ff;
   logic [c2d_pkg::POS_W-1:0]        rsp_row_ff, rsp_col_ff;
   logic                             rsp_err_ff;

   // datapath
   logic [KW-1:0]               len_eff, len_m1, pad, kr, kc;
   logic [c2d_pkg::DIM_W-1:0]   rows_eff, cols_eff;
   logic                        pos_err, i_last, j_last, in_img;
   logic signed [WW-1:0]        ir, ic;
   logic                        k_we, i_we;
   logic [KAW-1:0]              k_waddr, k_raddr;
   logic [IAW-1:0]              i_waddr, i_raddr;
   logic [DATA_WIDTH-1:0]       wr_data;
   logic signed [DATA_WIDTH-1:0] k_rdata, i_rdata;

   // ---------------------------------------------------------------------
   // effective configuration (oversize settings saturate)
   // ---------------------------------------------------------------------
   assign len_eff  = (32'(kernel_len_ff) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_len_ff);
   assign rows_eff = (32'(image_rows_ff) > MAX_ROWS) ? c2d_pkg::DIM_W'(MAX_ROWS) : image_rows_ff;
   assign cols_eff = (32'(image_cols_ff) > MAX_COLS) ? c2d_pkg::DIM_W'(MAX_COLS) : image_cols_ff;
   assign len_m1   = len_eff - KW'(1);
   assign pad      = len_m1 >> 1;

   assign pos_err = (c2d_pkg::DIM_W'(req_row) >= rows_eff) ||
                    (c2d_pkg::DIM_W'(req_col) >= cols_eff);

   // ---------------------------------------------------------------------
   // store writes
   // ---------------------------------------------------------------------
   assign wr_data = DATA_WIDTH'(req_value);

   assign k_we    = req_valid && req_ready && (req_operation == c2d_pkg::OP_KERNEL_WR) &&
                    (32'(req_row) < MAX_KERNEL) && (32'(req_col) < MAX_KERNEL);
   assign k_waddr = KAW'(32'(req_row) * MAX_KERNEL + 32'(req_col));

   assign i_we    = req_valid && req_ready && (req_operation == c2d_pkg::OP_PIXEL_WR) &&
                    (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_COLS);
   assign i_waddr = IAW'(32'(req_row) * MAX_COLS + 32'(req_col));

   // ---------------------------------------------------------------------
   // window walk: address generation for the current tap
   // ---------------------------------------------------------------------
   assign ir = signed'(WW'(row_ff) + WW'(i_ff) - WW'(pad));
   assign ic = signed'(WW'(col_ff) + WW'(j_ff) - WW'(pad));

   assign in_img = !ir[WW-1] && (ir[WW-2:0] < (WW-1)'(rows_eff)) &&
                   !ic[WW-1] && (ic[WW-2:0] < (WW-1)'(cols_eff));

   // convolution mode reads the kernel rotated by 180 degrees
   assign kr = flip_ff ? KW'(len_m1 - i_ff) : i_ff;
   assign kc = flip_ff ? KW'(len_m1 - j_ff) : j_ff;

   assign k_raddr = KAW'(32'(kr) * MAX_KERNEL + 32'(kc));
   assign i_raddr = IAW'(32'(ir[WW-2:0]) * MAX_COLS + 32'(ic[WW-2:0]));

   assign i_last = (i_ff == len_m1);
   assign j_last = (j_ff == len_m1);

   c2d_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (KDEPTH)
   ) u_kernel_ram (
      .clock (clock),
      .we    (k_we),
      .waddr (k_waddr),
      .wdata (wr_data),
      .raddr (k_raddr),
      .rdata (k_rdata)
   );

   c2d_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (IDEPTH)
   ) u_image_ram (
      .clock (clock),
      .we    (i_we),
      .waddr (i_waddr),
      .wdata (wr_data),
      .raddr (i_raddr),
      .rdata (i_rdata)
   );

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      start     = 1'b0;
      issue     = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         c2d_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_operation == c2d_pkg::OP_COMPUTE)) begin
               start = 1'b1;
               if (pos_err || (len_eff == '0)) begin
                  state_in = c2d_pkg::ST_DONE;
               end else begin
                  state_in = c2d_pkg::ST_RUN;
               end
            end
         end
         c2d_pkg::ST_RUN: begin
            issue = 1'b1;
            if (i_last && j_last) begin
               state_in = c2d_pkg::ST_DRAIN;
            end
         end
         c2d_pkg::ST_DRAIN: begin
            // last tap is in the multiply stage; it lands in acc at this edge
            if (!p1_ff) begin
               state_in = c2d_pkg::ST_DONE;
            end
         end
         c2d_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = c2d_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = c2d_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= c2d_pkg::ST_IDLE;
         p1_ff         <= 1'b0;
         p2_ff         <= 1'b0;
         in1_ff        <= 1'b0;
         in2_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         kernel_len_ff <= c2d_pkg::KLEN_W'(3);
         image_rows_ff <= c2d_pkg::DIM_W'(64);
         image_cols_ff <= c2d_pkg::DIM_W'(64);
         flip_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         p1_ff    <= issue;
         p2_ff    <= p1_ff;
         in1_ff   <= issue && in_img;
         in2_ff   <= in1_ff;

         if (start) begin
            i_ff <= '0;
            j_ff <= '0;
         end else if (issue) begin
            if (j_last) begin
               j_ff <= '0;
               i_ff <= i_ff + KW'(1);
            end else begin
               j_ff <= j_ff + KW'(1);
            end
         end

         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               c2d_pkg::CSR_KERNEL_LENGTH: kernel_len_ff <= csr_wdata[c2d_pkg::KLEN_W-1:0];
               c2d_pkg::CSR_IMAGE_ROWS:    image_rows_ff <= csr_wdata;
               c2d_pkg::CSR_IMAGE_COLS:    image_cols_ff <= csr_wdata;
               c2d_pkg::CSR_FLIP_KERNEL:   flip_ff       <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // multiply-accumulate and response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      prod_ff <= k_rdata * i_rdata;

      if (start) begin
         row_ff <= req_row;
         col_ff <= req_col;
         err_ff <= pos_err;
         acc_ff <= '0;
      end else if (p2_ff && in2_ff) begin
         acc_ff <= acc_ff + c2d_pkg::SUM_W'(prod_ff);
      end

      if (load_rsp) begin
         rsp_sum_ff <= acc_ff;
         rsp_row_ff <= row_ff;
         rsp_col_ff <= col_ff;
         rsp_err_ff <= err_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sum            = rsp_sum_ff;
   assign rsp_out_row        = rsp_row_ff;
   assign rsp_out_col        = rsp_col_ff;
   assign rsp_position_error = rsp_err_ff;
   assign csr_ready          = 1'b1;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_err_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == c2d_pkg::ST_DONE && err_ff) |-> (acc_ff == '0))
      else $error("position error with nonzero sum");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == c2d_pkg::ST_IDLE) |-> (!p1_ff && !p2_ff))
      else $error("MAC pipeline busy while idle");

   a_kaddr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == c2d_pkg::ST_RUN) |-> (32'(k_raddr) < KDEPTH))
      else $error("kernel read address out of range");

   a_iaddr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == c2d_pkg::ST_RUN && in_img) |-> (32'(i_raddr) < IDEPTH))
      else $error("image read address out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == c2d_pkg::ST_DONE))
      else $error("response raised outside completion");

endmodule

[verif/tb_conv2d_same_padding.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_same_padding
// Self-checking bench for the same-padding 2-D filter. Kernel and pixel
// writes and compute requests run under a series of register settings.
// Each response is checked against a behavioral window-sum predictor.
// ----------------------------------------------------------------------------
module tb_conv2d_same_padding;

   localparam int CLK_PERIOD   = 10;
   localparam int MAX_K        = 7;
   localparam int IMG_DIM      = 64;
   localparam int RANDOM_ITEMS = 1200;
   localparam int PHASE_ITEMS  = 90;
   localparam int LATENCY_PAD  = 64;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int IDLE_PCT     = 23;
   localparam int CALM_PHASE   = 8;
   localparam logic [c2d_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic signed [c2d_pkg::SUM_W-1:0] sum;
      logic [c2d_pkg::POS_W-1:0]        row;
      logic [c2d_pkg::POS_W-1:0]        col;
      logic                             err;
   } filter_result_type;

   class filter_scoreboard;
      logic signed [c2d_pkg::VALUE_W-1:0] kernel_mem [MAX_K*MAX_K];
      logic signed [c2d_pkg::VALUE_W-1:0] image_mem [IMG_DIM*IMG_DIM];
      logic [c2d_pkg::KLEN_W-1:0] klen;
      logic [c2d_pkg::DIM_W-1:0]  rows;
      logic [c2d_pkg::DIM_W-1:0]  cols;
      logic                       flip;
      filter_result_type          expected_sums [$];
      int                         mismatches;
      int                         requests_seen;

      function new();
         klen          = 3;
         rows          = 64;
         cols          = 64;
         flip          = 1'b0;
         mismatches    = 0;
         requests_seen = 0;
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction

      function void write_register(logic [c2d_pkg::CSR_IDX_W-1:0] idx,
                                   logic [c2d_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            c2d_pkg::CSR_KERNEL_LENGTH: klen = data[c2d_pkg::KLEN_W-1:0];
            c2d_pkg::CSR_IMAGE_ROWS:    rows = data[c2d_pkg::DIM_W-1:0];
            c2d_pkg::CSR_IMAGE_COLS:    cols = data[c2d_pkg::DIM_W-1:0];
            c2d_pkg::CSR_FLIP_KERNEL:   flip = data[0];
            default: ;
         endcase
      endfunction

      function filter_result_type filter_at(logic [c2d_pkg::POS_W-1:0] row,
                                            logic [c2d_pkg::POS_W-1:0] col);
         filter_result_type res;
         logic signed [2*c2d_pkg::VALUE_W-1:0] prod;
         int len, nrows, ncols, pad, i, j, ir, ic, kr, kc;
         len     = (klen > MAX_K) ? MAX_K : klen;
         nrows   = (rows > IMG_DIM) ? IMG_DIM : rows;
         ncols   = (cols > IMG_DIM) ? IMG_DIM : cols;
         res.sum = '0;
         res.row = row;
         res.col = col;
         res.err = (row >= nrows) || (col >= ncols);
         if (!res.err) begin
            pad = (len - 1) / 2;
            for (i = 0; i < len; i++) begin
               ir = int'(row) - pad + i;
               if (ir < 0 || ir >= nrows) continue;
               for (j = 0; j < len; j++) begin
                  ic = int'(col) - pad + j;
                  if (ic < 0 || ic >= ncols) continue;
                  // convolution reads the kernel rotated by 180 degrees
                  kr      = flip ? len - 1 - i : i;
                  kc      = flip ? len - 1 - j : j;
                  prod    = kernel_mem[kr*MAX_K + kc] * image_mem[ir*IMG_DIM + ic];
                  res.sum = res.sum + prod;
               end
            end
         end
         return res;
      endfunction

      function void accept_request(logic [c2d_pkg::OP_W-1:0] op,
                                   logic [c2d_pkg::POS_W-1:0] row,
                                   logic [c2d_pkg::POS_W-1:0] col,
                                   logic signed [c2d_pkg::VALUE_W-1:0] value);
         requests_seen++;
         case (op)
            c2d_pkg::OP_KERNEL_WR:
               if (row < MAX_K && col < MAX_K) kernel_mem[row*MAX_K + col] = value;
            c2d_pkg::OP_PIXEL_WR:
               image_mem[{row, col}] = value;
            c2d_pkg::OP_COMPUTE:
               expected_sums.push_back(filter_at(row, col));
            default: ;
         endcase
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function void check_response(logic signed [c2d_pkg::SUM_W-1:0] sum,
                                   logic [c2d_pkg::POS_W-1:0] row,
                                   logic [c2d_pkg::POS_W-1:0] col, logic err);
         filter_result_type want;
         if (expected_sums.size() == 0) begin
            flag($sformatf("unexpected response: sum %0d row %0d col %0d err %0b",
                           sum, row, col, err));
            return;
         end
         want = expected_sums.pop_front();
         if (sum !== want.sum || row !== want.row || col !== want.col || err !== want.err)
            flag($sformatf({"response error: want sum %0d row %0d col %0d err %0b,",
                            " got sum %0d row %0d col %0d err %0b"},
                           want.sum, want.row, want.col, want.err, sum, row, col, err));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   logic                               req_valid;
   logic                               req_ready;
   logic [c2d_pkg::OP_W-1:0]           req_operation;
   logic [c2d_pkg::POS_W-1:0]          req_row;
   logic [c2d_pkg::POS_W-1:0]          req_col;
   logic signed [c2d_pkg::VALUE_W-1:0] req_value;

   logic                               rsp_valid;
   logic                               rsp_ready;
   logic signed [c2d_pkg::SUM_W-1:0]   rsp_sum;
   logic [c2d_pkg::POS_W-1:0]          rsp_out_row;
   logic [c2d_pkg::POS_W-1:0]          rsp_out_col;
   logic                               rsp_position_error;

   logic                               csr_valid;
   logic                               csr_ready;
   logic [c2d_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [c2d_pkg::CSR_DATA_W-1:0]     csr_wdata;

   filter_scoreboard sb = new();

   // stimulus-side view of the settings and of which entries hold data
   int cfg_len   = 3;
   int cfg_rows  = 64;
   int cfg_cols  = 64;
   bit calm      = 1'b0;
   int items_sent = 0;
   bit kernel_written [MAX_K*MAX_K];
   bit pixel_written [IMG_DIM*IMG_DIM];

   conv2d_same_padding DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sum            (rsp_sum),
      .rsp_out_row        (rsp_out_row),
      .rsp_out_col        (rsp_out_col),
      .rsp_position_error (rsp_position_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         // check before noting: a response never belongs to a request of this edge
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_sum, rsp_out_row, rsp_out_col, rsp_position_error);
         if (req_valid && req_ready)
            sb.accept_request(req_operation, req_row, req_col, req_value);
         if (csr_valid && csr_ready)
            sb.write_register(csr_index, csr_wdata);
      end
   end

   function automatic logic signed [c2d_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return -16'sd1;
         3: return 16'sd0;
         default: return c2d_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [c2d_pkg::CSR_DATA_W-1:0] dim_setting();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 15) return c2d_pkg::CSR_DATA_W'($urandom_range(13, 127));
      return c2d_pkg::CSR_DATA_W'($urandom_range(1, 12));
   endfunction

   task automatic send_request(input logic [c2d_pkg::OP_W-1:0] op,
                               input logic [c2d_pkg::POS_W-1:0] row,
                               input logic [c2d_pkg::POS_W-1:0] col,
                               input logic signed [c2d_pkg::VALUE_W-1:0] value);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_row       <= row;
      req_col       <= col;
      req_value     <= value;
      do @(posedge clock); while (!req_ready);
      if (op == c2d_pkg::OP_KERNEL_WR && row < MAX_K && col < MAX_K)
         kernel_written[row*MAX_K + col] = 1'b1;
      if (op == c2d_pkg::OP_PIXEL_WR)
         pixel_written[{row, col}] = 1'b1;
      if (op != OP_UNUSED &&
          !(op == c2d_pkg::OP_KERNEL_WR && (row >= MAX_K || col >= MAX_K)))
         items_sent++;
   endtask

   // fill whatever the window will read that has never been written, then compute
   task automatic compute_at(input logic [c2d_pkg::POS_W-1:0] row,
                             input logic [c2d_pkg::POS_W-1:0] col);
      int pad, i, j, ir, ic;
      if (cfg_len > 0 && row < cfg_rows && col < cfg_cols) begin
         for (i = 0; i < cfg_len; i++)
            for (j = 0; j < cfg_len; j++)
               if (!kernel_written[i*MAX_K + j])
                  send_request(c2d_pkg::OP_KERNEL_WR, c2d_pkg::POS_W'(i),
                               c2d_pkg::POS_W'(j), random_value());
         pad = (cfg_len - 1) / 2;
         for (i = 0; i < cfg_len; i++) begin
            for (j = 0; j < cfg_len; j++) begin
               ir = int'(row) - pad + i;
               ic = int'(col) - pad + j;
               if (ir >= 0 && ir < cfg_rows && ic >= 0 && ic < cfg_cols &&
                   !pixel_written[ir*IMG_DIM + ic])
                  send_request(c2d_pkg::OP_PIXEL_WR, c2d_pkg::POS_W'(ir),
                               c2d_pkg::POS_W'(ic), random_value());
            end
         end
      end
      send_request(c2d_pkg::OP_COMPUTE, row, col, random_value());
   endtask

   task automatic csr_write(input logic [c2d_pkg::CSR_IDX_W-1:0] idx,
                            input logic [c2d_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // drop valid, wait for every response, then let trailing writes retire
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   initial begin : response_sink
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && !reset && sb.requests_seen >= 300 && sb.pending() > 0) begin
            // long hold-off: the block fills up and must stall its input
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held = 1'b1;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      logic signed [c2d_pkg::VALUE_W-1:0] corner_vals [9];
      logic [c2d_pkg::CSR_DATA_W-1:0] klen_w, rows_w, cols_w;
      logic flip_w;
      logic [c2d_pkg::POS_W-1:0] r, c;
      int phase, roll, i, random_base, phase_base;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= c2d_pkg::OP_KERNEL_WR;
      req_row       <= '0;
      req_col       <= '0;
      req_value     <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= c2d_pkg::CSR_KERNEL_LENGTH;
      csr_wdata     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 3x3 correlation over 64x64, extreme values
      corner_vals = '{16'sh8000, 16'sh7fff, -16'sd1, 16'sd0, 16'sd1,
                      16'sh5555, 16'shaaaa, 16'sh8000, 16'sh7fff};
      for (i = 0; i < 9; i++)
         send_request(c2d_pkg::OP_KERNEL_WR, c2d_pkg::POS_W'(i / 3),
                      c2d_pkg::POS_W'(i % 3), corner_vals[i]);
      send_request(OP_UNUSED, 6'd63, 6'd63, 16'sh7fff);
      send_request(c2d_pkg::OP_KERNEL_WR, 6'd63, 6'd63, 16'sh7fff);   // beyond store, dropped
      send_request(c2d_pkg::OP_KERNEL_WR, 6'd7, 6'd0, 16'sh8000);
      send_request(c2d_pkg::OP_PIXEL_WR, 6'd0, 6'd0, 16'sh8000);
      send_request(c2d_pkg::OP_PIXEL_WR, 6'd0, 6'd1, 16'sh7fff);
      send_request(c2d_pkg::OP_PIXEL_WR, 6'd1, 6'd0, 16'sh8000);
      send_request(c2d_pkg::OP_PIXEL_WR, 6'd1, 6'd1, 16'sh8000);
      compute_at(6'd0, 6'd0);
      for (i = 0; i < 4; i++)
         send_request(c2d_pkg::OP_PIXEL_WR, c2d_pkg::POS_W'(62 + i / 2),
                      c2d_pkg::POS_W'(62 + i % 2), 16'sh7fff);
      compute_at(6'd63, 6'd63);
      compute_at(6'd0, 6'd63);

      random_base = items_sent;
      phase = 0;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         case (phase)
            0: begin klen_w = 7;        rows_w = 64;  cols_w = 64;  flip_w = 1'b1; end
            1: begin klen_w = 1;        rows_w = 1;   cols_w = 1;   flip_w = 1'b0; end
            2: begin klen_w = 7'h78;    rows_w = 8;   cols_w = 8;   flip_w = 1'b1; end
            3: begin klen_w = 5;        rows_w = 0;   cols_w = 9;   flip_w = 1'b0; end
            4: begin klen_w = 4;        rows_w = 127; cols_w = 100; flip_w = 1'b1; end
            5: begin klen_w = 2;        rows_w = 6;   cols_w = 0;   flip_w = 1'b1; end
            6: begin klen_w = 7;        rows_w = 7;   cols_w = 7;   flip_w = 1'b0; end
            default: begin
               // upper data bits are don't-care for the kernel length
               klen_w = {4'($urandom_range(15)),
                         3'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 7))};
               rows_w = dim_setting();
               cols_w = dim_setting();
               flip_w = 1'($urandom_range(1));
            end
         endcase
         settle();
         csr_write(c2d_pkg::CSR_KERNEL_LENGTH, klen_w);
         csr_write(c2d_pkg::CSR_IMAGE_ROWS, rows_w);
         csr_write(c2d_pkg::CSR_IMAGE_COLS, cols_w);
         csr_write(c2d_pkg::CSR_FLIP_KERNEL, {{(c2d_pkg::CSR_DATA_W-1){1'b0}}, flip_w});
         csr_valid <= 1'b0;
         cfg_len  = klen_w[c2d_pkg::KLEN_W-1:0];
         cfg_rows = (rows_w > IMG_DIM) ? IMG_DIM : rows_w;
         cfg_cols = (cols_w > IMG_DIM) ? IMG_DIM : cols_w;
         calm     = (phase == CALM_PHASE);

         phase_base = items_sent;
         while (items_sent - phase_base < PHASE_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
               if ($urandom_range(99) < 85 && cfg_rows > 0 && cfg_cols > 0) begin
                  // on big images stay mostly in a corner that is already filled
                  r = c2d_pkg::POS_W'($urandom_range(
                         ($urandom_range(99) < 70 && cfg_rows > 12) ? 11 : cfg_rows - 1));
                  c = c2d_pkg::POS_W'($urandom_range(
                         ($urandom_range(99) < 70 && cfg_cols > 12) ? 11 : cfg_cols - 1));
               end else begin
                  r = c2d_pkg::POS_W'($urandom_range(63));
                  c = c2d_pkg::POS_W'($urandom_range(63));
               end
               compute_at(r, c);
            end else if (roll < 80) begin
               if ($urandom_range(99) < 80 && cfg_rows > 0 && cfg_cols > 0)
                  send_request(c2d_pkg::OP_PIXEL_WR,
                               c2d_pkg::POS_W'($urandom_range(cfg_rows - 1)),
                               c2d_pkg::POS_W'($urandom_range(cfg_cols - 1)),
                               random_value());
               else
                  send_request(c2d_pkg::OP_PIXEL_WR, c2d_pkg::POS_W'($urandom_range(63)),
                               c2d_pkg::POS_W'($urandom_range(63)), random_value());
            end else if (roll < 93) begin
               if ($urandom_range(99) < 80)
                  send_request(c2d_pkg::OP_KERNEL_WR,
                               c2d_pkg::POS_W'($urandom_range(MAX_K - 1)),
                               c2d_pkg::POS_W'($urandom_range(MAX_K - 1)),
                               random_value());
               else
                  send_request(c2d_pkg::OP_KERNEL_WR, c2d_pkg::POS_W'($urandom_range(63)),
                               c2d_pkg::POS_W'($urandom_range(63)), random_value());
            end else begin
               send_request(OP_UNUSED, c2d_pkg::POS_W'($urandom_range(63)),
                            c2d_pkg::POS_W'($urandom_range(63)), random_value());
            end
         end
         phase++;
      end
      calm = 1'b0;

      settle();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
hdl/c2d_pkg.sv
hdl/c2d_ram.sv
hdl/conv2d_same_padding.sv
verif/tb_conv2d_same_padding.sv
